// ----- design/gcsp_pkg.sv -----
// gcsp_pkg: shared constants, register indexes and types for the gray code
// stripe pattern generator. No dependencies.
`timescale 1ns / 1ps

package gcsp_pkg;

  // configuration register widths, fixed by the register map
  localparam int DIM_REG_W   = 13;
  localparam int LIMIT_W     = 4;
  localparam int INDEX_W     = 6;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_COUNT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LIMIT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_INDEX = 2'd3;

  localparam logic [DIM_REG_W-1:0] COLUMN_COUNT_RESET  = 13'd1024;
  localparam logic [DIM_REG_W-1:0] ROW_COUNT_RESET     = 13'd768;
  localparam logic [LIMIT_W-1:0]   PATTERN_LIMIT_RESET = 4'd4;
  localparam logic [INDEX_W-1:0]   PATTERN_INDEX_RESET = 6'd0;

  localparam int LEVEL_W = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'hff;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'h00;

  // compare width for pattern index against sequence bounds
  localparam int CLASS_W = 8;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PAT_FLAT  = 2'd0,
    PAT_VERT  = 2'd1,
    PAT_HORIZ = 2'd2,
    PAT_BAD   = 2'd3
  } pat_kind_t;

endpackage

// ----- design/gcsp_cfg.sv -----
// gcsp_cfg: configuration registers and the frame geometry derived from them
// (bit counts, offsets, last positions, plane count). Uses gcsp_pkg.
`timescale 1ns / 1ps

module gcsp_cfg import gcsp_pkg::*; #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_write,
  input  logic [CFG_ADDR_W-1:0]                           cfg_index,
  input  logic [CFG_DATA_W-1:0]                           cfg_data,
  output logic [MAX_DIM_BITS-1:0]                         cols_last,
  output logic [MAX_DIM_BITS-1:0]                         rows_last,
  output logic [$clog2(MAX_DIM_BITS+1)-1:0]               vbits,
  output logic [$clog2(MAX_DIM_BITS+1)-1:0]               hbits,
  output logic [MAX_DIM_BITS-1:0]                         voffset,
  output logic [MAX_DIM_BITS-1:0]                         hoffset,
  output logic [(($clog2(MAX_DIM_BITS+1) > LIMIT_W) ?
                 $clog2(MAX_DIM_BITS+1) : LIMIT_W)-1:0]   planes,
  output logic [INDEX_W-1:0]                              pattern_index
);

  localparam int DCW = MAX_DIM_BITS + 1;
  localparam int BW  = $clog2(MAX_DIM_BITS + 1);
  localparam int EW  = (DCW > DIM_REG_W) ? DCW : DIM_REG_W;
  localparam int NW  = (BW > LIMIT_W) ? BW : LIMIT_W;

  logic [LIMIT_W-1:0] pattern_limit;

  function automatic logic [DCW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
    logic [EW-1:0] ext;
    logic [EW-1:0] maxd;
    ext  = EW'(d);
    maxd = EW'(1) << MAX_DIM_BITS;
    if (ext == '0) begin
      clamp_dim = DCW'(1);
    end else if (ext > maxd) begin
      clamp_dim = DCW'(maxd);
    end else begin
      clamp_dim = DCW'(ext);
    end
  endfunction

  // smallest n >= 1 with 2^n >= d
  function automatic logic [BW-1:0] bits_for(input logic [DCW-1:0] d);
    logic [BW-1:0] n;
    n = BW'(1);
    for (int k = 1; k < MAX_DIM_BITS; k++) begin
      if ((DCW'(1) << k) < d) n = BW'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [MAX_DIM_BITS-1:0] offset_for(input logic [DCW-1:0] d,
                                                         input logic [BW-1:0]  n);
    logic [DCW-1:0] span;
    span = (DCW'(1) << n) - d;
    return span[MAX_DIM_BITS:1];
  endfunction

  logic [DIM_REG_W-1:0] col_src, row_src;
  logic [DCW-1:0]       col_dim, row_dim, col_lastw, row_lastw;
  logic [BW-1:0]        col_bits, row_bits;

  // reset loads the same geometry a write of the reset values would
  always_comb begin
    col_src   = rst ? COLUMN_COUNT_RESET : cfg_data;
    row_src   = rst ? ROW_COUNT_RESET : cfg_data;
    col_dim   = clamp_dim(col_src);
    row_dim   = clamp_dim(row_src);
    col_bits  = bits_for(col_dim);
    row_bits  = bits_for(row_dim);
    col_lastw = col_dim - DCW'(1);
    row_lastw = row_dim - DCW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_last     <= col_lastw[MAX_DIM_BITS-1:0];
      vbits         <= col_bits;
      voffset       <= offset_for(col_dim, col_bits);
      rows_last     <= row_lastw[MAX_DIM_BITS-1:0];
      hbits         <= row_bits;
      hoffset       <= offset_for(row_dim, row_bits);
      pattern_limit <= PATTERN_LIMIT_RESET;
      pattern_index <= PATTERN_INDEX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT: begin
          cols_last <= col_lastw[MAX_DIM_BITS-1:0];
          vbits     <= col_bits;
          voffset   <= offset_for(col_dim, col_bits);
        end
        REG_ROW_COUNT: begin
          rows_last <= row_lastw[MAX_DIM_BITS-1:0];
          hbits     <= row_bits;
          hoffset   <= offset_for(row_dim, row_bits);
        end
        REG_PATTERN_LIMIT: pattern_limit <= cfg_data[LIMIT_W-1:0];
        REG_PATTERN_INDEX: pattern_index <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // planes per direction: min of both bit counts and the requested limit
  logic [NW-1:0] vb_n, hb_n, lim_n, min_bits;

  always_comb begin
    vb_n     = NW'(vbits);
    hb_n     = NW'(hbits);
    lim_n    = NW'(pattern_limit);
    min_bits = (vb_n < hb_n) ? vb_n : hb_n;
    planes   = (lim_n < min_bits) ? lim_n : min_bits;
  end

endmodule

// ----- design/gcsp_front.sv -----
// gcsp_front: takes tick requests, walks the raster and classifies each pixel
// into a queue entry (pattern kind, polarity, code bit index, position, row and
// frame end). Uses gcsp_pkg.
`timescale 1ns / 1ps

module gcsp_front import gcsp_pkg::*; #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            tick_valid,
  output logic                                            tick_stall,
  input  logic                                            restart,
  input  logic                                            full,
  output logic                                            push,
  output logic [2 + 1 + $clog2(MAX_DIM_BITS) + MAX_DIM_BITS + 2 - 1:0] entry,
  input  logic [MAX_DIM_BITS-1:0]                         cols_last,
  input  logic [MAX_DIM_BITS-1:0]                         rows_last,
  input  logic [$clog2(MAX_DIM_BITS+1)-1:0]               vbits,
  input  logic [$clog2(MAX_DIM_BITS+1)-1:0]               hbits,
  input  logic [(($clog2(MAX_DIM_BITS+1) > LIMIT_W) ?
                 $clog2(MAX_DIM_BITS+1) : LIMIT_W)-1:0]   planes,
  input  logic [INDEX_W-1:0]                              pattern_index
);

  localparam int IW = $clog2(MAX_DIM_BITS);

  logic [MAX_DIM_BITS-1:0] column_position, row_position;
  logic [MAX_DIM_BITS-1:0] col_cur, row_cur;
  logic                    rend, fend;

  logic [CLASS_W-1:0] pe, half, lim_v, lim_h, bit_v, bit_h;
  pat_kind_t          kind;
  logic [IW-1:0]      bit_sel;
  logic [MAX_DIM_BITS-1:0] pos_sel;

  assign tick_stall = full;
  assign push       = tick_valid & ~full;

  always_comb begin
    col_cur = restart ? '0 : column_position;
    row_cur = restart ? '0 : row_position;
    rend    = col_cur >= cols_last;
    fend    = rend && (row_cur >= rows_last);
  end

  always_comb begin
    pe    = CLASS_W'(pattern_index);
    half  = pe >> 1;
    lim_v = (CLASS_W'(planes) << 1) + CLASS_W'(2);
    lim_h = (CLASS_W'(planes) << 2) + CLASS_W'(2);
    bit_v = CLASS_W'(vbits) - half;
    bit_h = CLASS_W'(hbits) + CLASS_W'(planes) - half;
    priority if (pe < CLASS_W'(2)) begin
      kind = PAT_FLAT;
    end else if (pe < lim_v) begin
      kind = PAT_VERT;
    end else if (pe < lim_h) begin
      kind = PAT_HORIZ;
    end else begin
      kind = PAT_BAD;
    end
    pos_sel = (kind == PAT_HORIZ) ? row_cur : col_cur;
    bit_sel = (kind == PAT_HORIZ) ? bit_h[IW-1:0] : bit_v[IW-1:0];
  end

  assign entry = {kind, ~pattern_index[0], bit_sel, pos_sel, rend, fend};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (push) begin
      if (rend) begin
        column_position <= '0;
        row_position    <= fend ? '0 : row_cur + MAX_DIM_BITS'(1);
      end else begin
        column_position <= col_cur + MAX_DIM_BITS'(1);
        row_position    <= row_cur;
      end
    end
  end

endmodule

// ----- design/gcsp_queue.sv -----
// gcsp_queue: short register queue between the raster front and the pixel
// back end. Uses gcsp_pkg for its depth.
`timescale 1ns / 1ps

module gcsp_queue import gcsp_pkg::*; #(
  parameter int WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      count;

  assign full    = count == (PW + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (PW + 1)'(1);
        2'b01:   count <= count - (PW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/gcsp_back.sv -----
// gcsp_back: turns a queue entry into a pixel: offset, gray code, bit pick,
// polarity, then the output register. Uses gcsp_pkg.
`timescale 1ns / 1ps

module gcsp_back import gcsp_pkg::*; #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [2 + 1 + $clog2(MAX_DIM_BITS) + MAX_DIM_BITS + 2 - 1:0] entry,
  input  logic                     empty,
  output logic                     pop,
  input  logic [MAX_DIM_BITS-1:0]  voffset,
  input  logic [MAX_DIM_BITS-1:0]  hoffset,
  output logic                     pixel_valid,
  input  logic                     pixel_stall,
  output logic [LEVEL_W-1:0]       pixel_level,
  output logic                     row_end,
  output logic                     frame_end,
  output logic                     bad_pattern
);

  localparam int IW  = $clog2(MAX_DIM_BITS);
  localparam int DCW = MAX_DIM_BITS + 1;

  logic [1:0]              kind_bits;
  pat_kind_t               kind;
  logic                    even, rend, fend, code_set;
  logic [IW-1:0]           bit_sel;
  logic [MAX_DIM_BITS-1:0] pos, offset, code_word;
  logic [DCW-1:0]          shifted;
  logic [LEVEL_W-1:0]      level;

  assign {kind_bits, even, bit_sel, pos, rend, fend} = entry;
  assign kind = pat_kind_t'(kind_bits);

  assign pop = ~empty & (~pixel_valid | ~pixel_stall);

  always_comb begin
    offset    = (kind == PAT_HORIZ) ? hoffset : voffset;
    shifted   = DCW'(pos) + DCW'(offset);
    code_word = shifted[MAX_DIM_BITS-1:0] ^ shifted[MAX_DIM_BITS:1];
    code_set  = code_word[bit_sel];
    unique case (kind)
      PAT_FLAT:  level = even ? LEVEL_HIGH : LEVEL_LOW;
      PAT_VERT,
      PAT_HORIZ: level = (code_set == even) ? LEVEL_HIGH : LEVEL_LOW;
      PAT_BAD:   level = LEVEL_LOW;
      default:   level = LEVEL_LOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (pop) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_level <= level;
      row_end     <= rend;
      frame_end   <= fend;
      bad_pattern <= (kind == PAT_BAD);
    end
  end

endmodule

// ----- design/gray_code_stripe_pattern_generator.sv -----
// gray_code_stripe_pattern_generator: top level of the structured-light stripe
// generator. Depends on gcsp_pkg, gcsp_cfg, gcsp_front, gcsp_queue, gcsp_back.
//
// usage
//   tick channel (tick_valid / tick_stall, payload restart): each accepted
//   request produces exactly one pixel in row-major order over the frame;
//   restart=1 moves the raster to row 0, column 0 before that pixel.
//   pixel channel (pixel_valid / pixel_stall): pixel_level is 0 or 255,
//   row_end and frame_end mark the last pixel of a row and of the frame,
//   bad_pattern flags a pattern index past the end of the sequence.
//   cfg_write / cfg_index / cfg_data write column_count, row_count,
//   pattern_limit and pattern_index; write only while no pixel is in flight.
// pipeline and throughput
//   a request accepted by the front is written into the queue, then popped
//   into the back end output register, where its pixel shows. one pixel per
//   cycle sustained while pixel_stall is low; the front, the four-entry queue
//   and the output register each move one entry a cycle.
// reset and stall
//   rst (synchronous) loads the default registers (1024 x 768, 4 planes,
//   pattern 0), homes the raster and empties the queue. while pixel_stall is
//   high the output holds; the queue fills and tick_stall rises when it is full.
`timescale 1ns / 1ps

module gray_code_stripe_pattern_generator import gcsp_pkg::*; #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_stall,
  input  logic                  restart,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output logic [LEVEL_W-1:0]    pixel_level,
  output logic                  row_end,
  output logic                  frame_end,
  output logic                  bad_pattern,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BW      = $clog2(MAX_DIM_BITS + 1);
  localparam int NW      = (BW > LIMIT_W) ? BW : LIMIT_W;
  localparam int ENTRY_W = 2 + 1 + $clog2(MAX_DIM_BITS) + MAX_DIM_BITS + 2;

  logic [MAX_DIM_BITS-1:0] cols_last, rows_last, voffset, hoffset;
  logic [BW-1:0]           vbits, hbits;
  logic [NW-1:0]           planes;
  logic [INDEX_W-1:0]      pattern_index;

  logic               push, pop, full, empty;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;

  gcsp_cfg #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cols_last     (cols_last),
    .rows_last     (rows_last),
    .vbits         (vbits),
    .hbits         (hbits),
    .voffset       (voffset),
    .hoffset       (hoffset),
    .planes        (planes),
    .pattern_index (pattern_index)
  );

  gcsp_front #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .tick_valid    (tick_valid),
    .tick_stall    (tick_stall),
    .restart       (restart),
    .full          (full),
    .push          (push),
    .entry         (wr_entry),
    .cols_last     (cols_last),
    .rows_last     (rows_last),
    .vbits         (vbits),
    .hbits         (hbits),
    .planes        (planes),
    .pattern_index (pattern_index)
  );

  gcsp_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .full    (full),
    .empty   (empty)
  );

  gcsp_back #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (rd_entry),
    .empty       (empty),
    .pop         (pop),
    .voffset     (voffset),
    .hoffset     (hoffset),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_level (pixel_level),
    .row_end     (row_end),
    .frame_end   (frame_end),
    .bad_pattern (bad_pattern)
  );

endmodule

// ----- design/gcsp_checker.sv -----
// gcsp_checker: port-level checks on the pixel channel of the stripe
// generator, bound to the top level. Uses gcsp_pkg.
`timescale 1ns / 1ps

module gcsp_checker import gcsp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_stall,
  input logic [LEVEL_W-1:0] pixel_level,
  input logic               row_end,
  input logic               frame_end,
  input logic               bad_pattern
);

  // a stalled pixel stays and keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_level) &&
      $stable(row_end) && $stable(frame_end) && $stable(bad_pattern))
    else $error("stalled pixel changed");

  a_level: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel_level == LEVEL_HIGH) || (pixel_level == LEVEL_LOW))
    else $error("pixel level not black or white");

  a_bad_black: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && bad_pattern |-> pixel_level == LEVEL_LOW)
    else $error("bad pattern pixel not black");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  a_reset_idle: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel valid right after reset");

endmodule

bind gray_code_stripe_pattern_generator gcsp_checker u_gcsp_checker (.*);
